[hdl/psvd_pkg.sv]
// shared types, codes and tables of the plot stream vector decoder
// no dependencies; every other file but psvd_scaler refers to it by scoped names
package psvd_pkg;

  typedef enum logic [2:0] {
    ARG_BAD,
    ARG_NONE,
    ARG_S16,
    ARG_F64,
    ARG_U8,
    ARG_TEXT
  } arg_type_t;

  typedef struct packed {
    arg_type_t  kind;
    logic [2:0] count;
  } cmd_info_t;

  // event codes
  localparam logic [2:0] KIND_SEGMENT     = 3'd0;
  localparam logic [2:0] KIND_LABEL_CHAR  = 3'd1;
  localparam logic [2:0] KIND_LABEL_END   = 3'd2;
  localparam logic [2:0] KIND_NEW_PAGE    = 3'd3;
  localparam logic [2:0] KIND_LINE_STYLE  = 3'd4;
  localparam logic [2:0] KIND_BAD_COMMAND = 3'd5;

  localparam logic [2:0] STYLE_UNKNOWN = 3'd5;

  // configuration register indexes
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [15:0] SCREEN_RESET = 16'd4096;
  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_ERASE     = "e";
  localparam logic [7:0]  CH_LABEL     = "t";

  localparam int STYLE_COUNT = 5;
  localparam logic [87:0] STYLE_NAME [STYLE_COUNT] = '{
    "solid", "dotted", "longdashed", "shortdashed", "dotdashed"
  };
  localparam logic [3:0] STYLE_LEN [STYLE_COUNT] = '{4'd5, 4'd6, 4'd10, 4'd11, 4'd9};

  // character of a style name at a position, zero past its end
  function automatic logic [7:0] style_char(input int k, input logic [3:0] pos);
    int sh;
    sh = 8 * (int'(STYLE_LEN[k]) - 1 - int'(pos));
    if (sh < 0) return 8'h00;
    return STYLE_NAME[k][sh +: 8];
  endfunction

  // argument format and count of each command letter
  function automatic cmd_info_t lookup(input logic [7:0] c);
    cmd_info_t r;
    r.kind  = ARG_BAD;
    r.count = 3'd0;
    unique case (c)
      "C":                 begin r.kind = ARG_U8;   r.count = 3'd3; end
      "F", "e":            begin r.kind = ARG_NONE; r.count = 3'd0; end
      "L", "S", "a":       begin r.kind = ARG_S16;  r.count = 3'd6; end
      "M", "N", "P", "c":  begin r.kind = ARG_S16;  r.count = 3'd3; end
      "O", "Q", "X", "i":  begin r.kind = ARG_F64;  r.count = 3'd3; end
      "V", "W", "r":       begin r.kind = ARG_F64;  r.count = 3'd6; end
      "f", "t":            begin r.kind = ARG_TEXT; r.count = 3'd1; end
      "l", "s":            begin r.kind = ARG_S16;  r.count = 3'd4; end
      "m", "n", "p":       begin r.kind = ARG_S16;  r.count = 3'd2; end
      "o", "q", "x":       begin r.kind = ARG_F64;  r.count = 3'd2; end
      "v", "w":            begin r.kind = ARG_F64;  r.count = 3'd4; end
      default:             begin r.kind = ARG_BAD;  r.count = 3'd0; end
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic       take;
    logic       step;
    logic       map_start;
    logic [1:0] map_idx;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic       step_result;
    logic       step_map;
    logic [1:0] step_map_last;
    logic       map_done;
    logic       out_free;
  } status_t;

endpackage

[hdl/psvd_scaler.sv]
// multi-cycle screen mapping unit: (p - lo) * span / (hi - lo), truncated and saturated
// uses psvd_pkg nothing; restoring divider, one quotient bit per cycle
module psvd_scaler #(
  parameter int COORD_BITS        = 32,
  parameter int SCREEN_WIDTH_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] p,
  input  logic signed [COORD_BITS-1:0] lo,
  input  logic signed [COORD_BITS-1:0] hi,
  input  logic [15:0]                  span,
  output logic                         done,
  output logic [23:0]                  value
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + 16;
  localparam int QB = SCREEN_WIDTH_BITS - 1;
  localparam int RW = PW + QB;
  localparam int CNTW = $clog2(QB + 1);

  typedef enum logic [4:0] {
    SC_IDLE = 5'b00001,
    SC_MUL  = 5'b00010,
    SC_CMP  = 5'b00100,
    SC_DIV  = 5'b01000,
    SC_DONE = 5'b10000
  } sc_state_t;

  sc_state_t state, state_next;

  logic signed [DW-1:0] n_val, d_val;
  logic [DW-1:0]        nm, dm;
  logic                 neg, dz, sat;
  logic [15:0]          span_q;
  logic [RW-1:0]        rem, dsh, dm_wide;
  logic [PW-1:0]        prod;
  logic [QB-1:0]        quo;
  logic [CNTW-1:0]      iter;
  logic signed [SCREEN_WIDTH_BITS-1:0] scr;

  assign n_val   = {p[COORD_BITS-1], p} - {lo[COORD_BITS-1], lo};
  assign d_val   = {hi[COORD_BITS-1], hi} - {lo[COORD_BITS-1], lo};
  assign prod    = PW'(nm) * PW'(span_q);
  assign dm_wide = RW'(dm) << QB;

  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE: if (start) state_next = SC_MUL;
      SC_MUL:  state_next = SC_CMP;
      SC_CMP:  state_next = (rem >= dm_wide) ? SC_DONE : SC_DIV;
      SC_DIV:  if (iter == '0) state_next = SC_DONE;
      SC_DONE: state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SC_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SC_IDLE: if (start) begin
        nm     <= n_val[DW-1] ? DW'(-n_val) : n_val;
        dm     <= d_val[DW-1] ? DW'(-d_val) : d_val;
        neg    <= n_val[DW-1] ^ d_val[DW-1];
        dz     <= (d_val == '0);
        span_q <= span;
      end
      SC_MUL: begin
        rem <= {{QB{1'b0}}, prod};
      end
      SC_CMP: begin
        sat  <= (rem >= dm_wide);
        dsh  <= dm_wide >> 1;
        quo  <= '0;
        iter <= CNTW'(QB - 1);
      end
      SC_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QB-2:0], 1'b1};
        end else begin
          quo <= {quo[QB-2:0], 1'b0};
        end
        dsh  <= dsh >> 1;
        iter <= iter - CNTW'(1);
      end
      SC_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    priority if (dz)   scr = '0;
    else if (sat && neg) scr = {1'b1, {QB{1'b0}}};
    else if (sat)        scr = {1'b0, {QB{1'b1}}};
    else if (neg)        scr = -$signed({1'b0, quo});
    else                 scr = $signed({1'b0, quo});
  end

  assign done  = (state == SC_DONE);
  assign value = 24'(scr);

endmodule

[hdl/psvd_ctrl.sv]
// controller state machine: byte handshake, step, mapping sequence, result hand-off
// depends on psvd_pkg for the command and status structs
module psvd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  psvd_pkg::status_t  status,
  output psvd_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_STEP      = 5'b00010,
    S_MAP_START = 5'b00100,
    S_MAP_WAIT  = 5'b01000,
    S_EMIT      = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [1:0] map_idx, map_idx_next;
  logic [1:0] map_last, map_last_next;

  always_comb begin
    state_next    = state;
    map_idx_next  = map_idx;
    map_last_next = map_last;
    cmd           = '0;
    cmd.map_idx   = map_idx;
    unique case (state)
      S_IDLE: begin
        cmd.take = byte_valid;
        if (byte_valid) state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        priority if (status.step_map) begin
          map_idx_next  = 2'd0;
          map_last_next = status.step_map_last;
          state_next    = S_MAP_START;
        end else if (status.step_result) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MAP_START: begin
        cmd.map_start = 1'b1;
        state_next    = S_MAP_WAIT;
      end
      S_MAP_WAIT: begin
        if (status.map_done) begin
          if (map_idx == map_last) state_next = S_EMIT;
          else begin
            map_idx_next = map_idx + 2'd1;
            state_next   = S_MAP_START;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      map_idx  <= 2'd0;
      map_last <= 2'd0;
    end else begin
      state    <= state_next;
      map_idx  <= map_idx_next;
      map_last <= map_last_next;
    end
  end

  assign byte_stall = (state != S_IDLE);

endmodule

[hdl/psvd_datapath.sv]
// datapath: decoder state, argument conversion, command execution, output register
// depends on psvd_pkg and instantiates psvd_scaler
module psvd_datapath #(
  parameter int COORD_FRAC_BITS   = 8,
  parameter int COORD_WIDTH       = 32,
  parameter int SCREEN_WIDTH_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [7:0]        stream_byte,
  input  psvd_pkg::cmd_t    cmd,
  output psvd_pkg::status_t status,
  input  logic              event_stall,
  output logic              event_valid,
  output logic [2:0]        event_kind,
  output logic signed [23:0] x_start,
  output logic signed [23:0] y_start,
  output logic signed [23:0] x_end,
  output logic signed [23:0] y_end,
  output logic [7:0]        text_byte,
  output logic [2:0]        style_code
);

  localparam int CW = COORD_WIDTH;
  localparam int F  = COORD_FRAC_BITS;
  // window has room for its reset value whatever the format
  localparam int WINW = (CW > F + 14) ? CW : F + 14;
  localparam int ARG_SLOTS = 5;
  localparam logic signed [WINW-1:0] WIN_MAX_RESET = WINW'(64'd4096 << F);

  function automatic logic signed [CW-1:0] sat_coord(input logic neg, input logic [63:0] mag);
    logic [63:0] lim;
    lim = 64'd1 << (CW - 1);
    if (neg) begin
      if (mag >= lim) return {1'b1, {(CW-1){1'b0}}};
      return CW'(64'd0 - mag);
    end
    if (mag >= lim) return {1'b0, {(CW-1){1'b1}}};
    return mag[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] from_short(input logic [15:0] raw);
    if (raw > 16'h7FFF) return sat_coord(1'b1, (64'h10000 - {48'd0, raw}) << F);
    return sat_coord(1'b0, {48'd0, raw} << F);
  endfunction

  function automatic logic signed [CW-1:0] from_double(input logic [63:0] bits);
    logic               neg;
    logic [10:0]        e;
    logic [63:0]        m;
    logic [63:0]        lim;
    logic [63:0]        mag;
    logic signed [13:0] sh;
    logic signed [13:0] nsh;
    neg = bits[63];
    e   = bits[62:52];
    m   = {12'd0, bits[51:0]};
    lim = 64'd1 << (CW - 1);
    if (e == 11'h7FF) begin
      if (m != 64'd0) return '0;
      return sat_coord(neg, lim);
    end
    if (e != 11'd0) m[52] = 1'b1;
    else e = 11'd1;
    if (m == 64'd0) return '0;
    sh  = $signed({3'b000, e}) - 14'sd1075 + 14'(F);
    nsh = -sh;
    if (sh >= 14'sd0) begin
      if (sh >= 14'sd48)                mag = lim;
      else if (m > (lim >> sh[5:0]))    mag = lim;
      else                              mag = m << sh[5:0];
    end else begin
      if (nsh >= 14'sd64) mag = 64'd0;
      else                mag = m >> nsh[5:0];
    end
    return sat_coord(neg, mag);
  endfunction

  // architectural state
  logic [7:0]             cur_byte;
  logic [7:0]             active_cmd, active_next;
  logic [5:0]             arg_cnt, cnt_next;
  logic [63:0]            assembler, asm_next;
  logic signed [CW-1:0]   arg_val   [ARG_SLOTS];
  logic signed [CW-1:0]   args_next [ARG_SLOTS];
  logic signed [WINW-1:0] win       [4];
  logic signed [WINW-1:0] win_next  [4];
  logic signed [CW-1:0]   cp        [2];
  logic signed [CW-1:0]   cp_next   [2];
  logic                   in_string, str_next;
  logic [4:0]             cand, cand_next;
  logic [3:0]             str_pos, pos_next;
  logic [15:0]            scr_w, scr_h;

  // pending result
  logic signed [WINW-1:0] seg_pt  [4];
  logic signed [WINW-1:0] pt_next [4];
  logic [2:0]             pend_kind, kind_n;
  logic [7:0]             pend_text, text_n;
  logic [2:0]             pend_style, style_n;
  logic [23:0]            res [4];
  logic                   has_res, need_map;
  logic [1:0]             map_last;

  psvd_pkg::cmd_info_t    info_b, info_a;
  logic [5:0]             cnt_inc, total, idx;
  logic [63:0]            asm_shift;
  logic signed [CW-1:0]   conv;
  logic                   store;

  logic                   map_done;
  logic [23:0]            map_value;

  always_comb begin
    info_b      = psvd_pkg::lookup(cur_byte);
    info_a      = psvd_pkg::lookup(active_cmd);
    active_next = active_cmd;
    cnt_next    = arg_cnt;
    asm_next    = assembler;
    args_next   = arg_val;
    win_next    = win;
    cp_next     = cp;
    str_next    = in_string;
    cand_next   = cand;
    pos_next    = str_pos;
    pt_next     = seg_pt;
    has_res     = 1'b0;
    need_map    = 1'b0;
    map_last    = 2'd0;
    kind_n      = psvd_pkg::KIND_SEGMENT;
    text_n      = 8'd0;
    style_n     = 3'd0;
    asm_shift   = {assembler[55:0], cur_byte};
    cnt_inc     = arg_cnt + 6'd1;
    total       = 6'd0;
    idx         = 6'd0;
    store       = 1'b0;
    conv        = '0;

    if (active_cmd == 8'd0) begin
      unique case (info_b.kind)
        psvd_pkg::ARG_BAD: begin
          has_res = 1'b1;
          kind_n  = psvd_pkg::KIND_BAD_COMMAND;
          text_n  = cur_byte;
        end
        psvd_pkg::ARG_NONE: begin
          if (cur_byte == psvd_pkg::CH_ERASE) begin
            has_res = 1'b1;
            kind_n  = psvd_pkg::KIND_NEW_PAGE;
          end
        end
        psvd_pkg::ARG_TEXT: begin
          active_next = cur_byte;
          cnt_next    = 6'd0;
          str_next    = 1'b1;
          cand_next   = 5'h1F;
          pos_next    = 4'd0;
        end
        default: begin
          active_next = cur_byte;
          cnt_next    = 6'd0;
        end
      endcase
    end else if (in_string) begin
      if (cur_byte == psvd_pkg::CH_NEWLINE) begin
        str_next    = 1'b0;
        active_next = 8'd0;
        has_res     = 1'b1;
        if (active_cmd == psvd_pkg::CH_LABEL) begin
          kind_n     = psvd_pkg::KIND_LABEL_END;
          need_map   = 1'b1;
          map_last   = 2'd1;
          pt_next[0] = WINW'(cp[0]);
          pt_next[1] = WINW'(cp[1]);
        end else begin
          kind_n  = psvd_pkg::KIND_LINE_STYLE;
          style_n = psvd_pkg::STYLE_UNKNOWN;
          for (int k = 0; k < psvd_pkg::STYLE_COUNT; k++)
            if (cand[k] && psvd_pkg::STYLE_LEN[k] == str_pos) style_n = 3'(k);
        end
      end else if (active_cmd == psvd_pkg::CH_LABEL) begin
        has_res = 1'b1;
        kind_n  = psvd_pkg::KIND_LABEL_CHAR;
        text_n  = cur_byte;
      end else begin
        for (int k = 0; k < psvd_pkg::STYLE_COUNT; k++)
          if (str_pos >= psvd_pkg::STYLE_LEN[k] ||
              psvd_pkg::style_char(k, str_pos) != cur_byte)
            cand_next[k] = 1'b0;
        if (str_pos != 4'd15) pos_next = str_pos + 4'd1;
      end
    end else if (info_a.kind == psvd_pkg::ARG_S16 || info_a.kind == psvd_pkg::ARG_F64 ||
                 info_a.kind == psvd_pkg::ARG_U8) begin
      asm_next = asm_shift;
      cnt_next = cnt_inc;
      unique case (info_a.kind)
        psvd_pkg::ARG_S16: begin
          total = {2'b00, info_a.count, 1'b0};
          store = ~cnt_inc[0];
          idx   = {1'b0, cnt_inc[5:1]} - 6'd1;
          conv  = from_short({asm_shift[7:0], asm_shift[15:8]});
        end
        psvd_pkg::ARG_F64: begin
          total = {info_a.count, 3'b000};
          store = (cnt_inc[2:0] == 3'd0);
          idx   = {3'b000, cnt_inc[5:3]} - 6'd1;
          conv  = from_double(asm_shift);
        end
        default: begin
          total = {3'b000, info_a.count};
          store = 1'b1;
          idx   = cnt_inc - 6'd1;
          conv  = sat_coord(1'b0, {56'd0, asm_shift[7:0]} << F);
        end
      endcase
      for (int i = 0; i < ARG_SLOTS; i++)
        if (store && idx == 6'(i)) args_next[i] = conv;

      if (cnt_inc >= total) begin
        active_next = 8'd0;
        cnt_next    = 6'd0;
        unique case (active_cmd)
          "s", "w": begin
            win_next[0] = WINW'(args_next[0]); win_next[1] = WINW'(args_next[1]);
            win_next[2] = WINW'(args_next[2]); win_next[3] = WINW'(args_next[3]);
          end
          "S", "W": begin
            win_next[0] = WINW'(args_next[0]); win_next[1] = WINW'(args_next[1]);
            win_next[2] = WINW'(args_next[3]); win_next[3] = WINW'(args_next[4]);
          end
          "m", "o", "M", "O": begin
            cp_next[0] = args_next[0];
            cp_next[1] = args_next[1];
          end
          "n", "q", "N", "Q", "l", "v", "L", "V", "p", "x", "P", "X": begin
            has_res  = 1'b1;
            need_map = 1'b1;
            map_last = 2'd3;
            kind_n   = psvd_pkg::KIND_SEGMENT;
            pt_next[0] = WINW'(args_next[0]);
            pt_next[1] = WINW'(args_next[1]);
            pt_next[2] = WINW'(args_next[0]);
            pt_next[3] = WINW'(args_next[1]);
            cp_next[0] = args_next[0];
            cp_next[1] = args_next[1];
            unique case (active_cmd)
              "n", "q", "N", "Q": begin
                pt_next[0] = WINW'(cp[0]);
                pt_next[1] = WINW'(cp[1]);
              end
              "l", "v": begin
                pt_next[2] = WINW'(args_next[2]);
                pt_next[3] = WINW'(args_next[3]);
                cp_next[0] = args_next[2];
                cp_next[1] = args_next[3];
              end
              "L", "V": begin
                pt_next[2] = WINW'(args_next[3]);
                pt_next[3] = WINW'(args_next[4]);
                cp_next[0] = args_next[3];
                cp_next[1] = args_next[4];
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end else begin
      active_next = 8'd0;
      cnt_next    = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cmd <= 8'd0;
      arg_cnt    <= 6'd0;
      assembler  <= 64'd0;
      for (int i = 0; i < ARG_SLOTS; i++) arg_val[i] <= '0;
      win[0]     <= '0;
      win[1]     <= '0;
      win[2]     <= WIN_MAX_RESET;
      win[3]     <= WIN_MAX_RESET;
      cp[0]      <= '0;
      cp[1]      <= '0;
      in_string  <= 1'b0;
      cand       <= 5'h1F;
      str_pos    <= 4'd0;
      scr_w      <= psvd_pkg::SCREEN_RESET;
      scr_h      <= psvd_pkg::SCREEN_RESET;
    end else begin
      if (cmd.step) begin
        active_cmd <= active_next;
        arg_cnt    <= cnt_next;
        assembler  <= asm_next;
        arg_val    <= args_next;
        win        <= win_next;
        cp         <= cp_next;
        in_string  <= str_next;
        cand       <= cand_next;
        str_pos    <= pos_next;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          psvd_pkg::REG_SCREEN_WIDTH:  scr_w <= cfg_data;
          psvd_pkg::REG_SCREEN_HEIGHT: scr_h <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) cur_byte <= stream_byte;
    if (cmd.step) begin
      seg_pt     <= pt_next;
      pend_kind  <= kind_n;
      pend_text  <= text_n;
      pend_style <= style_n;
      for (int i = 0; i < 4; i++) res[i] <= 24'd0;
    end else if (map_done) begin
      res[cmd.map_idx] <= map_value;
    end
    if (cmd.load_out) begin
      event_kind <= pend_kind;
      x_start    <= res[0];
      y_start    <= res[1];
      x_end      <= res[2];
      y_end      <= res[3];
      text_byte  <= pend_text;
      style_code <= pend_style;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)               event_valid <= 1'b0;
    else if (cmd.load_out) event_valid <= 1'b1;
    else if (!event_stall) event_valid <= 1'b0;
  end

  psvd_scaler #(
    .COORD_BITS        (WINW),
    .SCREEN_WIDTH_BITS (SCREEN_WIDTH_BITS)
  ) u_scaler (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.map_start),
    .p     (seg_pt[cmd.map_idx]),
    .lo    (win[{1'b0, cmd.map_idx[0]}]),
    .hi    (win[{1'b1, cmd.map_idx[0]}]),
    .span  (cmd.map_idx[0] ? scr_h : scr_w),
    .done  (map_done),
    .value (map_value)
  );

  assign status.step_result   = has_res;
  assign status.step_map      = need_map;
  assign status.step_map_last = map_last;
  assign status.map_done      = map_done;
  assign status.out_free      = !event_valid || !event_stall;

endmodule

[hdl/plot_stream_vector_decoder_top.sv]
// top level of the plot stream vector decoder
// depends on psvd_pkg, psvd_ctrl, psvd_datapath (and through it psvd_scaler)

// Decodes a plot byte stream one byte per transfer and emits at most one event
// per byte: segments in screen coordinates, label characters and label ends,
// new page, line style and bad command events. Bytes are taken one at a time:
// a byte that only feeds a command is accepted, then decoded in the step state;
// one that yields a plain event then waits to load the output register. A byte
// that ends a draw command also runs the screen mapping for four coordinates
// through one shared scaler, each pass going through setup, multiply, range
// check, one quotient bit per cycle for SCREEN_WIDTH_BITS - 1 bits, and finish
// (a saturated coordinate or an empty window, hi equal to lo, skips the
// quotient bits); a label end maps two coordinates. The result sits in an
// output register, so the next byte is accepted while an event is still
// stalled; a new event waits only for that register to empty. screen_width and
// screen_height are written through cfg_write/cfg_index/cfg_data; the user
// must do so only while no byte is being worked on, and the block itself does
// not enforce it.
module plot_stream_vector_decoder_top #(
  parameter int COORD_FRAC_BITS   = 8,
  parameter int COORD_WIDTH       = 32,
  parameter int SCREEN_WIDTH_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  // byte channel
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic [7:0]        stream_byte,
  // event channel
  output logic              event_valid,
  input  logic              event_stall,
  output logic [2:0]        event_kind,
  output logic signed [23:0] x_start,
  output logic signed [23:0] y_start,
  output logic signed [23:0] x_end,
  output logic signed [23:0] y_end,
  output logic [7:0]        text_byte,
  output logic [2:0]        style_code
);

  // commands from the controller, status back from the datapath
  psvd_pkg::cmd_t    cmd;
  psvd_pkg::status_t status;

  // sequencing: one byte in flight, mapping steps, output hand-off
  psvd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // decoder state, conversion, scaler and output register
  psvd_datapath #(
    .COORD_FRAC_BITS   (COORD_FRAC_BITS),
    .COORD_WIDTH       (COORD_WIDTH),
    .SCREEN_WIDTH_BITS (SCREEN_WIDTH_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .stream_byte (stream_byte),
    .cmd         (cmd),
    .status      (status),
    .event_stall (event_stall),
    .event_valid (event_valid),
    .event_kind  (event_kind),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .text_byte   (text_byte),
    .style_code  (style_code)
  );

endmodule

[hdl/psvd_checker.sv]
// port-level checks of the plot stream vector decoder, bound to the top level
// depends on psvd_pkg for event codes
module psvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_stall,
  input logic        event_valid,
  input logic        event_stall,
  input logic [2:0]  event_kind,
  input logic [23:0] x_end,
  input logic [23:0] y_end
);

  // stalled event holds
  a_event_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=> event_valid && $stable(event_kind) && $stable(x_end))
    else $error("stalled event changed");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !event_valid)
    else $error("event valid after reset");

  // one byte at a time
  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall |=> byte_stall)
    else $error("second byte taken while decoding");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> event_kind <= psvd_pkg::KIND_BAD_COMMAND)
    else $error("event kind out of range");

  // only segments carry an end point
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind != psvd_pkg::KIND_SEGMENT |-> x_end == 24'd0 && y_end == 24'd0)
    else $error("end point on non-segment event");

endmodule

bind plot_stream_vector_decoder_top psvd_checker u_psvd_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_stall  (byte_stall),
  .event_valid (event_valid),
  .event_stall (event_stall),
  .event_kind  (event_kind),
  .x_end       (x_end),
  .y_end       (y_end)
);

[tb/tb_plot_stream_vector_decoder_top.sv]
// self-checking testbench of plot_stream_vector_decoder_top
// depends on psvd_pkg and the decoder RTL; holds its own plot stream decoder model
`timescale 1ns / 100ps

module tb_plot_stream_vector_decoder_top;

  localparam int IDLE_LIMIT = 5000;   // cycles with no transfer before giving up
  localparam int DRAIN_WAIT = 200;    // covers four scaler passes at the default width
  localparam logic [63:0] LIM_COORD = 64'd1 << 31;
  localparam logic [63:0] LIM_SCREEN = 64'd1 << 23;

  // one event as the block reports it
  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] xs;
    logic [23:0] ys;
    logic [23:0] xe;
    logic [23:0] ye;
    logic [7:0]  text;
    logic [2:0]  style;
  } plot_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = psvd_pkg::REG_SCREEN_WIDTH;
  logic [15:0] cfg_data = '0;
  logic byte_valid = 1'b0;
  logic byte_stall;
  logic [7:0] stream_byte = '0;
  logic event_valid;
  logic event_stall = 1'b0;
  logic [2:0] event_kind;
  logic signed [23:0] x_start, y_start, x_end, y_end;
  logic [7:0] text_byte;
  logic [2:0] style_code;

  plot_stream_vector_decoder_top dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .stream_byte(stream_byte),
    .event_valid(event_valid), .event_stall(event_stall), .event_kind(event_kind),
    .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .text_byte(text_byte), .style_code(style_code)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // decoder model state, mirrors the block after reset
  // ---------------------------------------------------------------------
  logic [15:0] span_x, span_y;
  logic [7:0]  cur_cmd;
  int          arg_bytes;
  logic [63:0] assembler;
  longint      arg_val [6];
  longint      window [4];     // xmin, ymin, xmax, ymax
  longint      pen [2];        // current point
  logic        in_text;
  logic [4:0]  style_live;
  int          text_pos;
  string       style_name [5] = '{"solid", "dotted", "longdashed", "shortdashed", "dotdashed"};

  plot_event_t expected_events [$];
  logic [7:0]  pending_bytes [$];   // stimulus built but not yet sent

  int errors = 0;
  int send_gap_max = 17;
  int recv_gap_max = 17;
  int recv_wait = 0;
  int hold_cycles = 0;
  int idle_count = 0;

  task automatic model_reset();
    span_x = psvd_pkg::SCREEN_RESET;
    span_y = psvd_pkg::SCREEN_RESET;
    cur_cmd = 8'd0;
    arg_bytes = 0;
    assembler = '0;
    foreach (arg_val[i]) arg_val[i] = 0;
    window[0] = 0;
    window[1] = 0;
    window[2] = longint'(4096) << 8;
    window[3] = longint'(4096) << 8;
    pen[0] = 0;
    pen[1] = 0;
    in_text = 1'b0;
    style_live = 5'h1F;
    text_pos = 0;
  endtask

  // argument format and count of a command letter
  function automatic psvd_pkg::arg_type_t arg_format(input logic [7:0] c, output int n);
    n = 0;
    case (c)
      "C": begin n = 3; return psvd_pkg::ARG_U8; end
      "F", "e": return psvd_pkg::ARG_NONE;
      "L", "S", "a": begin n = 6; return psvd_pkg::ARG_S16; end
      "M", "N", "P", "c": begin n = 3; return psvd_pkg::ARG_S16; end
      "O", "Q", "X", "i": begin n = 3; return psvd_pkg::ARG_F64; end
      "V", "W", "r": begin n = 6; return psvd_pkg::ARG_F64; end
      "f", "t": begin n = 1; return psvd_pkg::ARG_TEXT; end
      "l", "s": begin n = 4; return psvd_pkg::ARG_S16; end
      "m", "n", "p": begin n = 2; return psvd_pkg::ARG_S16; end
      "o", "q", "x": begin n = 2; return psvd_pkg::ARG_F64; end
      "v", "w": begin n = 4; return psvd_pkg::ARG_F64; end
      default: return psvd_pkg::ARG_BAD;
    endcase
  endfunction

  function automatic longint clamp_coord(input logic neg, input logic [63:0] mag);
    if (neg) begin
      if (mag >= LIM_COORD) return -longint'(LIM_COORD);
      return -longint'(mag);
    end
    if (mag >= LIM_COORD) return longint'(LIM_COORD - 1);
    return longint'(mag);
  endfunction

  function automatic longint coord_from_short(input logic [15:0] raw);
    if (raw > 16'h7FFF) return clamp_coord(1'b1, (64'h10000 - 64'(raw)) << 8);
    return clamp_coord(1'b0, 64'(raw) << 8);
  endfunction

  function automatic longint coord_from_double(input logic [63:0] bits);
    logic [63:0] m, mag;
    int ex, sh;
    ex = int'(bits[62:52]);
    m = {12'd0, bits[51:0]};
    if (ex == 2047) begin
      if (m != 0) return 0;    // nan
      return clamp_coord(bits[63], LIM_COORD);
    end
    if (ex != 0) m[52] = 1'b1;
    else ex = 1;               // subnormal
    if (m == 0) return 0;
    sh = ex - 1075 + 8;
    if (sh >= 0) begin
      if (sh >= 48 || m > (LIM_COORD >> sh)) mag = LIM_COORD;
      else mag = m << sh;
    end else begin
      mag = (-sh >= 64) ? 64'd0 : (m >> (-sh));
    end
    return clamp_coord(bits[63], mag);
  endfunction

  // exact truncated division onto the screen, saturated to 24 signed bits
  function automatic logic [23:0] to_screen(input longint p, input longint lo,
                                            input longint hi, input logic [15:0] span);
    longint n, d;
    logic [63:0] nm, dm, q;
    logic neg;
    n = p - lo;
    d = hi - lo;
    if (d == 0) return 24'd0;
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    neg = (n < 0) != (d < 0);
    q = nm * 64'(span) / dm;
    if (neg) begin
      if (q >= LIM_SCREEN) return 24'h800000;
      return 24'(-longint'(q));
    end
    if (q >= LIM_SCREEN) q = LIM_SCREEN - 1;
    return q[23:0];
  endfunction

  function automatic plot_event_t make_event(input logic [2:0] kind, input logic [23:0] xs,
      input logic [23:0] ys, input logic [23:0] xe, input logic [23:0] ye,
      input logic [7:0] text, input logic [2:0] style);
    plot_event_t r;
    r = '{kind, xs, ys, xe, ye, text, style};
    return r;
  endfunction

  task automatic draw_segment(input longint x1, input longint y1, input longint x2,
                              input longint y2);
    pen[0] = x2;
    pen[1] = y2;
    expected_events.push_back(make_event(psvd_pkg::KIND_SEGMENT,
        to_screen(x1, window[0], window[2], span_x), to_screen(y1, window[1], window[3], span_y),
        to_screen(x2, window[0], window[2], span_x), to_screen(y2, window[1], window[3], span_y),
        8'd0, 3'd0));
  endtask

  task automatic run_command(input logic [7:0] c);
    case (c)
      "s", "w": begin
        window[0] = arg_val[0]; window[1] = arg_val[1];
        window[2] = arg_val[2]; window[3] = arg_val[3];
      end
      "S", "W": begin
        window[0] = arg_val[0]; window[1] = arg_val[1];
        window[2] = arg_val[3]; window[3] = arg_val[4];
      end
      "m", "o", "M", "O": begin
        pen[0] = arg_val[0];
        pen[1] = arg_val[1];
      end
      "n", "q", "N", "Q": draw_segment(pen[0], pen[1], arg_val[0], arg_val[1]);
      "l", "v": draw_segment(arg_val[0], arg_val[1], arg_val[2], arg_val[3]);
      "L", "V": draw_segment(arg_val[0], arg_val[1], arg_val[3], arg_val[4]);
      "p", "x", "P", "X": draw_segment(arg_val[0], arg_val[1], arg_val[0], arg_val[1]);
      default: ;  // arcs, circles, color: nothing to report
    endcase
  endtask

  // advance the model by one accepted byte, queueing the event it causes
  task automatic decode_byte(input logic [7:0] b);
    psvd_pkg::arg_type_t fmt;
    int n, per, idx;
    logic [7:0] c;
    logic [2:0] code;
    longint v;
    if (cur_cmd == 8'd0) begin
      fmt = arg_format(b, n);
      if (fmt == psvd_pkg::ARG_BAD)
        expected_events.push_back(make_event(psvd_pkg::KIND_BAD_COMMAND, 24'd0, 24'd0,
            24'd0, 24'd0, b, 3'd0));
      else if (fmt == psvd_pkg::ARG_NONE) begin
        if (b == psvd_pkg::CH_ERASE)
          expected_events.push_back(make_event(psvd_pkg::KIND_NEW_PAGE, 24'd0, 24'd0,
              24'd0, 24'd0, 8'd0, 3'd0));
      end else begin
        cur_cmd = b;
        arg_bytes = 0;
        if (fmt == psvd_pkg::ARG_TEXT) begin
          in_text = 1'b1;
          style_live = 5'h1F;
          text_pos = 0;
        end
      end
    end else if (in_text) begin
      c = cur_cmd;
      if (b == psvd_pkg::CH_NEWLINE) begin
        in_text = 1'b0;
        cur_cmd = 8'd0;
        if (c == psvd_pkg::CH_LABEL) begin
          expected_events.push_back(make_event(psvd_pkg::KIND_LABEL_END,
              to_screen(pen[0], window[0], window[2], span_x),
              to_screen(pen[1], window[1], window[3], span_y), 24'd0, 24'd0, 8'd0, 3'd0));
        end else begin
          code = psvd_pkg::STYLE_UNKNOWN;
          for (int k = 0; k < 5; k++)
            if (style_live[k] && style_name[k].len() == text_pos) code = 3'(k);
          expected_events.push_back(make_event(psvd_pkg::KIND_LINE_STYLE, 24'd0, 24'd0,
              24'd0, 24'd0, 8'd0, code));
        end
      end else if (c == psvd_pkg::CH_LABEL) begin
        expected_events.push_back(make_event(psvd_pkg::KIND_LABEL_CHAR, 24'd0, 24'd0,
            24'd0, 24'd0, b, 3'd0));
      end else begin
        for (int k = 0; k < 5; k++)
          if (text_pos >= style_name[k].len() || style_name[k][text_pos] != b)
            style_live[k] = 1'b0;
        if (text_pos < 15) text_pos++;
      end
    end else begin
      fmt = arg_format(cur_cmd, n);
      per = (fmt == psvd_pkg::ARG_S16) ? 2 : (fmt == psvd_pkg::ARG_F64) ? 8 : 1;
      assembler = {assembler[55:0], b};
      arg_bytes = (arg_bytes + 1) & 63;
      if (arg_bytes % per == 0) begin
        idx = arg_bytes / per - 1;
        if (fmt == psvd_pkg::ARG_S16) v = coord_from_short({assembler[7:0], assembler[15:8]});
        else if (fmt == psvd_pkg::ARG_F64) v = coord_from_double(assembler);
        else v = clamp_coord(1'b0, 64'(assembler[7:0]) << 8);
        if (idx < 6) arg_val[idx] = v;
      end
      if (arg_bytes >= per * n) begin
        c = cur_cmd;
        cur_cmd = 8'd0;
        arg_bytes = 0;
        run_command(c);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // byte sender: one transfer per call, valid held across back-to-back bytes
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (byte_stall);
    decode_byte(b);
    @(negedge clk);
  endtask

  // send everything built so far, then drop valid for a cycle
  task automatic send_pending();
    while (pending_bytes.size() != 0) send_byte(pending_bytes.pop_front());
    byte_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // register writes only while idle; commands with no event may still be in flight
  task automatic write_screen(input logic [15:0] w, input logic [15:0] h);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= psvd_pkg::REG_SCREEN_WIDTH;
    cfg_data <= w;
    @(negedge clk);
    cfg_index <= psvd_pkg::REG_SCREEN_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_write <= 1'b0;
    span_x = w;
    span_y = h;
  endtask

  // ---------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------
  task automatic put_short(input logic [15:0] v);
    pending_bytes.push_back(v[7:0]);   // little-endian
    pending_bytes.push_back(v[15:8]);
  endtask

  task automatic put_double(input logic [63:0] v);
    for (int i = 7; i >= 0; i--) pending_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  function automatic logic [15:0] rand_short();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4, 5, 6: return 16'($urandom_range(0, 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_double();
    real r;
    case ($urandom_range(0, 15))
      0: return 64'h7FF8_0000_0000_0001;                         // nan
      1: return 64'h7FF0_0000_0000_0000;                         // +inf
      2: return 64'hFFF0_0000_0000_0000;                         // -inf
      3: return 64'h8000_0000_0000_0000;                         // -0
      4: return {12'd0, 20'($urandom), 32'($urandom)};           // subnormal
      5: return {$urandom_range(0, 1) == 1, 11'd1100, 20'($urandom), 32'($urandom)};
      6: return {$urandom, $urandom};
      7: return {1'b0, 11'd1053, 52'd0};                          // 2^30, saturates
      default: begin
        r = real'(int'($urandom_range(0, 2000000)) - 1000000) / 64.0;
        return $realtobits(r);
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    b = 8'($urandom);
    return (b == psvd_pkg::CH_NEWLINE) ? 8'h00 : b;
  endfunction

  // one random command with its arguments, sometimes cut short
  task automatic build_random_command();
    string letters = "CLSaMNPcOQXiVWrlsmnpoqxvw";
    logic [7:0] c;
    psvd_pkg::arg_type_t fmt;
    int n, pick, keep, len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      pending_bytes.push_back(8'($urandom));                     // noise
    end else if (pick < 12) begin
      pending_bytes.push_back(($urandom_range(0, 1) == 1) ? psvd_pkg::CH_ERASE : 8'("F"));
    end else if (pick < 20) begin
      pending_bytes.push_back(psvd_pkg::CH_LABEL);
      len = $urandom_range(0, 5);
      repeat (len) pending_bytes.push_back(rand_text_byte());
      pending_bytes.push_back(psvd_pkg::CH_NEWLINE);
    end else if (pick < 27) begin
      pending_bytes.push_back("f");
      case ($urandom_range(0, 3))
        0, 1: put_text(style_name[$urandom_range(0, 4)]);
        2: put_text(style_name[$urandom_range(0, 4)].substr(0, $urandom_range(0, 4)));
        default: begin
          len = $urandom_range(0, 18);   // runs past the saturating position
          repeat (len) pending_bytes.push_back(rand_text_byte());
        end
      endcase
      pending_bytes.push_back(psvd_pkg::CH_NEWLINE);
    end else begin
      c = (pick < 35) ? (($urandom_range(0, 1) == 1) ? 8'("s") : 8'("W"))
                      : letters[$urandom_range(0, letters.len() - 1)];
      fmt = arg_format(c, n);
      keep = pending_bytes.size();
      pending_bytes.push_back(c);
      repeat (n) begin
        if (fmt == psvd_pkg::ARG_S16) put_short(rand_short());
        else if (fmt == psvd_pkg::ARG_F64) put_double(rand_double());
        else pending_bytes.push_back(8'($urandom));
      end
      // broken sequence: drop a tail so the next command letter lands as an argument
      if ($urandom_range(0, 19) == 0)
        while (pending_bytes.size() > keep + 1 && $urandom_range(0, 2) != 0)
          void'(pending_bytes.pop_back());
    end
  endtask

  task automatic random_traffic(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      build_random_command();
      sent += pending_bytes.size();
      send_pending();
    end
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    pending_bytes.push_back(8'h00);        // bad bytes at both ends and just outside the letters
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back("@");
    pending_bytes.push_back("{");
    pending_bytes.push_back(psvd_pkg::CH_ERASE);
    pending_bytes.push_back("F");          // flush: nothing reported
    pending_bytes.push_back("m");
    put_short(16'h7FFF);
    put_short(16'h8000);
    pending_bytes.push_back("n");
    put_short(16'h8000);
    put_short(16'h7FFF);
    pending_bytes.push_back(psvd_pkg::CH_LABEL);     // label with a zero byte
    pending_bytes.push_back("A");
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(psvd_pkg::CH_NEWLINE);
    pending_bytes.push_back("f");
    put_text("dotted");
    pending_bytes.push_back(psvd_pkg::CH_NEWLINE);
    send_pending();
  endtask

  task automatic test_double_specials();
    pending_bytes.push_back("x");          // nan x, +inf y
    put_double(64'h7FF8_0000_0000_0000);
    put_double(64'h7FF0_0000_0000_0000);
    pending_bytes.push_back("x");          // -inf x, smallest subnormal y
    put_double(64'hFFF0_0000_0000_0000);
    put_double(64'h0000_0000_0000_0001);
    send_pending();
  endtask

  task automatic test_config_sweep();
    write_screen(16'd1, 16'd65535);
    random_traffic(80);
    write_screen(16'd65535, 16'd1);
    random_traffic(80);
    write_screen(16'd0, 16'hFFFF);         // zero span maps to 0
    random_traffic(60);
    write_screen(16'($urandom), 16'($urandom));
    random_traffic(80);
  endtask

  // receiver holds off while bad bytes keep coming, so the block backs up
  task automatic test_backpressure();
    hold_cycles = 300;
    repeat (12) pending_bytes.push_back("@");
    send_pending();
  endtask

  // sender stops mid command until the block has reported everything
  task automatic test_sender_pause();
    pending_bytes.push_back("l");
    put_short(rand_short());
    put_short(rand_short());
    send_pending();
    wait_drained();
    put_short(rand_short());
    put_short(rand_short());
    pending_bytes.push_back(psvd_pkg::CH_ERASE);
    send_pending();
  endtask

  task automatic test_no_idle();
    send_gap_max = 0;
    recv_gap_max = 0;
    random_traffic(100);
    send_gap_max = 17;
    recv_gap_max = 17;
  endtask

  // ---------------------------------------------------------------------
  // receiver stall, result checker, watchdog
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      event_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      event_stall <= 1'b1;
      hold_cycles--;
    end else if (recv_wait > 0) begin
      event_stall <= 1'b1;
      recv_wait--;
    end else begin
      event_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  plot_event_t want;
  always @(posedge clk) begin
    if (!rst && event_valid && !event_stall) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0d", $time, event_kind);
        errors++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", 24'(want.kind), 24'(event_kind));
        check_field("x_start", want.xs, x_start);
        check_field("y_start", want.ys, y_start);
        check_field("x_end", want.xe, x_end);
        check_field("y_end", want.ye, y_end);
        check_field("text_byte", 24'(want.text), 24'(text_byte));
        check_field("style_code", 24'(want.style), 24'(style_code));
      end
      recv_wait = (recv_gap_max == 0) ? 0 : $urandom_range(0, recv_gap_max);
    end
  end

  // any transfer on either side, a reset or a configuration write resets the count
  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (event_valid && !event_stall) || rst || cfg_write)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d events outstanding", $time, expected_events.size());
      $display("tb_plot_stream_vector_decoder_top: FAIL");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_double_specials();
    random_traffic(100);
    test_backpressure();
    test_sender_pause();
    test_no_idle();
    test_config_sweep();
    write_screen(psvd_pkg::SCREEN_RESET, psvd_pkg::SCREEN_RESET);
    random_traffic(60);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("tb_plot_stream_vector_decoder_top: PASS");
    else
      $display("tb_plot_stream_vector_decoder_top: FAIL");
    $finish;
  end

endmodule

[files.f]
hdl/psvd_pkg.sv
hdl/psvd_scaler.sv
hdl/psvd_ctrl.sv
hdl/psvd_datapath.sv
hdl/plot_stream_vector_decoder_top.sv
hdl/psvd_checker.sv
tb/tb_plot_stream_vector_decoder_top.sv
